// ===== design/multi_channel_heartbeat_watchdog_defines.svh =====
// Assertion macros shared by the heartbeat watchdog checker.
`ifndef MULTI_CHANNEL_HEARTBEAT_WATCHDOG_DEFINES_SVH
`define MULTI_CHANNEL_HEARTBEAT_WATCHDOG_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define MCHW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MCHW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/mchw_pkg.sv =====
// Shared types and constants of the multi-channel heartbeat watchdog.
package mchw_pkg;

   // Defaults of the top-level parameters.
   localparam int NUM_SLOTS_DEF = 8;
   localparam int ID_WIDTH_DEF  = 16;

   // Fixed field and register widths.
   localparam int FIELD_ID_W  = 16;
   localparam int REQ_TYPE_W  = 2;
   localparam int CSR_INDEX_W = 4;
   localparam int REG_COUNT   = 8;

   // Reset value of the slot 0 ID register.
   localparam logic [FIELD_ID_W-1:0] SLOT0_RESET = 16'd101;

   // Request kinds; the unused code is treated like an other event.
   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_HEARTBEAT = 2'd0,
      REQ_TICK      = 2'd1,
      REQ_OTHER     = 2'd2
   } req_kind_type;

   // Result actions.
   typedef enum logic {
      ACT_KICK    = 1'b0,
      ACT_RECOVER = 1'b1
   } action_type;

   // Output register occupancy as seen by the controller.
   typedef enum logic {
      ST_EMPTY = 1'b0,
      ST_FULL  = 1'b1
   } ctl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic hb_en;
      logic tick_en;
   } mchw_cmd_type;

endpackage

// ===== design/mchw_req_if.sv =====
// Request channel interface: heartbeat, tick and other event beats.
interface mchw_req_if
   import mchw_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [FIELD_ID_W-1:0] beat_id;

   modport source (output valid, output req_type, output beat_id, input ready);
   modport sink   (input valid, input req_type, input beat_id, output ready);
endinterface

// ===== design/mchw_rsp_if.sv =====
// Response channel interface: kick or recovery result beats.
interface mchw_rsp_if
   import mchw_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic                  action;
   logic [FIELD_ID_W-1:0] miss_id;

   modport source (output valid, output action, output miss_id, input ready);
   modport sink   (input valid, input action, input miss_id, output ready);
endinterface

// ===== design/mchw_ctrl.sv =====
// Controller: accepts request beats and tracks the result output register.
module mchw_ctrl
   import mchw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [REQ_TYPE_W-1:0] req_type,
   input  logic                  rsp_ready,
   output logic                  req_ready,
   output logic                  rsp_valid,
   output mchw_cmd_type          cmd
);

   ctl_state_type state_ff;
   ctl_state_type state_in;
   logic          accept;
   logic          is_tick;

   assign accept  = req_valid && req_ready;
   assign is_tick = (req_type == REQ_TICK);

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and handshake outputs.
   // Wherever the state can change, ready is high, so valid alone marks a beat.
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_EMPTY: begin
            req_ready = 1'b1;
            if (req_valid && is_tick) begin
               state_in = ST_FULL;
            end
         end
         ST_FULL: begin
            rsp_valid = 1'b1;
            req_ready = rsp_ready;
            if (rsp_ready) begin
               state_in = (req_valid && is_tick) ? ST_FULL : ST_EMPTY;
            end
         end
         default: begin
            state_in = ST_EMPTY;
         end
      endcase
   end

   // Datapath commands for the accepted beat.
   always_comb begin
      cmd.hb_en   = accept && (req_type == REQ_HEARTBEAT);
      cmd.tick_en = accept && is_tick;
   end

endmodule

// ===== design/mchw_datapath.sv =====
// Datapath: slot ID registers, alive flags, tick evaluation and result register.
module mchw_datapath
   import mchw_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF,
   parameter int ID_WIDTH  = ID_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mchw_cmd_type           cmd,
   input  logic [FIELD_ID_W-1:0]  req_beat_id,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [FIELD_ID_W-1:0]  csr_wdata,
   output logic                   rsp_action,
   output logic [FIELD_ID_W-1:0]  rsp_miss_id
);

   // IDs are compared on their low bits only, never wider than the field.
   localparam int CMP_W = (ID_WIDTH < FIELD_ID_W) ? ID_WIDTH : FIELD_ID_W;
   localparam logic [FIELD_ID_W-1:0] ID_MASK =
      FIELD_ID_W'((33'd1 << CMP_W) - 33'd1);

   logic [FIELD_ID_W-1:0] slot_ff [NUM_SLOTS];
   logic [FIELD_ID_W-1:0] slot_in [NUM_SLOTS];
   logic [NUM_SLOTS-1:0]  alive_ff;
   logic [NUM_SLOTS-1:0]  alive_in;
   logic                  action_ff;
   logic                  action_in;
   logic [FIELD_ID_W-1:0] failed_ff;
   logic [FIELD_ID_W-1:0] failed_in;

   logic [FIELD_ID_W-1:0] who;
   logic [FIELD_ID_W-1:0] slot_m [NUM_SLOTS];
   logic [NUM_SLOTS-1:0]  match;
   logic [NUM_SLOTS-1:0]  pending;
   logic                  any_fail;
   logic                  found;
   logic [FIELD_ID_W-1:0] worst;

   // Per-slot compares against the heartbeat sender and the alive flags.
   always_comb begin
      who = req_beat_id & ID_MASK;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         slot_m[i]  = slot_ff[i] & ID_MASK;
         match[i]   = (who != '0) && (slot_m[i] == who);
         pending[i] = (slot_m[i] != '0) && !alive_ff[i];
      end
   end

   // Smallest enabled ID that has not sent a heartbeat since the last kick.
   always_comb begin
      found = 1'b0;
      worst = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (pending[i] && (!found || (slot_m[i] < worst))) begin
            worst = slot_m[i];
            found = 1'b1;
         end
      end
      any_fail = found;
   end

   // Next values of slot IDs and alive flags.
   always_comb begin
      slot_in  = slot_ff;
      alive_in = alive_ff;
      if (cmd.hb_en) begin
         alive_in = alive_ff | match;
      end
      if (cmd.tick_en && !any_fail) begin
         alive_in = '0;
      end
      // A register write also clears the alive flag of its slot.
      if (csr_we) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (csr_index == CSR_INDEX_W'(i)) begin
               slot_in[i]  = csr_wdata;
               alive_in[i] = 1'b0;
            end
         end
      end
   end

   // Result payload, loaded on every accepted tick.
   always_comb begin
      action_in = action_ff;
      failed_in = failed_ff;
      if (cmd.tick_en) begin
         action_in = any_fail ? ACT_RECOVER : ACT_KICK;
         failed_in = any_fail ? worst : '0;
      end
   end

   // Configuration and flag registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_ff[i] <= (i == 0) ? (SLOT0_RESET & ID_MASK) : '0;
         end
         alive_ff <= '0;
      end else begin
         slot_ff  <= slot_in;
         alive_ff <= alive_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      action_ff <= action_in;
      failed_ff <= failed_in;
   end

   assign rsp_action  = action_ff;
   assign rsp_miss_id = failed_ff;

endmodule

// ===== design/multi_channel_heartbeat_watchdog.sv =====
// A tick beat's result is registered and offered in the cycle after it is accepted.
// Heartbeats and other events produce no result.
// Throughput: one request beat per cycle while a held result is not stalled;
// the result register frees as it drains. The slot compare and minimum scan are combinational.
// Reset (synchronous): alive flags clear, slot 0 ID is 101, others 0, no result.
module multi_channel_heartbeat_watchdog
   import mchw_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF,
   parameter int ID_WIDTH  = ID_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   mchw_req_if.sink               req_bus,
   mchw_rsp_if.source             rsp_bus,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [FIELD_ID_W-1:0]  csr_wdata
);

   mchw_cmd_type cmd;

   // Handshake control.
   mchw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_type  (req_bus.req_type),
      .rsp_ready (rsp_bus.ready),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .cmd       (cmd)
   );

   // Slot state and result evaluation.
   mchw_datapath #(
      .NUM_SLOTS (NUM_SLOTS),
      .ID_WIDTH  (ID_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_beat_id (req_bus.beat_id),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_action  (rsp_bus.action),
      .rsp_miss_id (rsp_bus.miss_id)
   );

endmodule

// ===== design/mchw_checker.sv =====
// Port-level checker for the heartbeat watchdog, bound to the top level.
`include "multi_channel_heartbeat_watchdog_defines.svh"

module mchw_checker
   import mchw_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic [REQ_TYPE_W-1:0] req_type,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_action,
   input logic [FIELD_ID_W-1:0] rsp_miss_id
);

   logic req_beat;

   assign req_beat = req_valid && req_ready;

   // A stalled result beat holds its payload.
   `MCHW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_action) && $stable(rsp_miss_id), "result beat changed while stalled")

   // A kick always reports a zero ID.
   `MCHW_ASSERT_NOW(a_kick_zero, clock, reset, rsp_valid && (rsp_action == ACT_KICK), rsp_miss_id == '0, "kick with nonzero failed ID")

   // A recovery never names the unused ID zero.
   `MCHW_ASSERT_NOW(a_recover_id, clock, reset, rsp_valid && (rsp_action == ACT_RECOVER), rsp_miss_id != '0, "recovery with zero failed ID")

   // Every accepted tick is followed by a result beat.
   `MCHW_ASSERT_NEXT(a_tick_result, clock, reset, req_beat && (req_type == REQ_TICK), rsp_valid, "tick produced no result")

   // Heartbeats and other events never create a result.
   `MCHW_ASSERT_NEXT(a_no_spurious, clock, reset, !rsp_valid && req_beat && (req_type != REQ_TICK), !rsp_valid, "result without a tick")

endmodule

bind multi_channel_heartbeat_watchdog mchw_checker u_mchw_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .req_type    (req_bus.req_type),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_action  (rsp_bus.action),
   .rsp_miss_id (rsp_bus.miss_id)
);
